// File: sv/oal_pkg.sv
// Shared types, codes and sizes for the ordered array list.
package oal_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int DATA_W = 32;
   localparam int POS_W = 8;
   localparam int INDEX_FIELD_W = 7;
   localparam int COUNT_FIELD_W = 8;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_FIND = 3'd2;
   localparam logic [2:0] OP_DELETE_VALUE = 3'd3;
   localparam logic [2:0] OP_DELETE_POS = 3'd4;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic [2:0]                operation;
      logic signed [DATA_W-1:0]  value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [INDEX_FIELD_W-1:0]  found_index;
      logic signed [DATA_W-1:0]  removed_value;
      logic [COUNT_FIELD_W-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_CLEAR,
      DP_REPORT,
      DP_UP_INIT,
      DP_SCAN_INIT,
      DP_SCAN_STEP,
      DP_FOUND,
      DP_POS_READ,
      DP_TAKE,
      DP_STEP,
      DP_DRAIN,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      rsp_status_type  code;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        full;
      logic        empty;
      logic        pos_ok;
      logic        match;
      logic        scan_last;
      logic        no_shift;
      logic        ptr_at_stop;
   } dp_status_type;

endpackage

// File: sv/oal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/oal_datapath.sv
// Datapath: request registers, entry count, pointers, entry memory and result registers.
module oal_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  oal_pkg::dp_cmd_type    cmd,
   input  oal_pkg::req_type       req_item,
   output oal_pkg::dp_status_type stat,
   output oal_pkg::rsp_type       rsp_item
);
   import oal_pkg::*;

   logic [2:0]         op_ff, op_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   rsp_status_type     status_ff, status_in;
   logic [IDX_W-1:0]   found_ff, found_in;
   logic [DATA_W-1:0]  removed_ff, removed_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [DATA_W-1:0]  rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [DATA_W-1:0]  wr_data;

   logic               is_insert;
   logic [IDX_W-1:0]   last_idx;
   logic [IDX_W-1:0]   clamp_pos;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;

   assign is_insert = (op_ff == OP_INSERT);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   // Insert past the end appends at the current count.
   assign clamp_pos = (pos_ext > cnt_ext) ? IDX_W'(count_ff) : IDX_W'(pos_ff);

   assign stat.op = op_ff;
   assign stat.full = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty = (count_ff == '0);
   assign stat.pos_ok = (pos_ext < cnt_ext);
   assign stat.match = rd_valid_ff && (rd_data == value_ff);
   assign stat.scan_last = rd_valid_ff && (rd_addr_ff == last_idx);
   assign stat.no_shift = is_insert ? (CNT_W'(index_ff) == count_ff) : (index_ff == last_idx);
   assign stat.ptr_at_stop = (ptr_ff == (is_insert ? index_ff : last_idx));

   always_comb begin
      rd_en = (cmd.op == DP_SCAN_STEP) || (cmd.op == DP_POS_READ) || (cmd.op == DP_STEP);
      rd_addr = (cmd.op == DP_POS_READ) ? IDX_W'(pos_ff) : ptr_ff;
      wr_en = 1'b0;
      wr_addr = is_insert ? (rd_addr_ff + IDX_W'(1)) : (rd_addr_ff - IDX_W'(1));
      wr_data = rd_data;
      // While shifting, the word read in the previous cycle lands one place over.
      if ((cmd.op == DP_STEP || cmd.op == DP_DRAIN) && rd_valid_ff) begin
         wr_en = 1'b1;
      end
      if (cmd.op == DP_FINISH && is_insert) begin
         wr_en = 1'b1;
         wr_addr = index_ff;
         wr_data = value_ff;
      end
   end

   always_comb begin
      op_in = op_ff;
      value_in = value_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      index_in = index_ff;
      ptr_in = ptr_ff;
      rd_valid_in = rd_en;
      rd_addr_in = rd_en ? rd_addr : rd_addr_ff;
      status_in = status_ff;
      found_in = found_ff;
      removed_in = removed_ff;
      unique case (cmd.op)
         DP_LOAD: begin
            op_in = req_item.operation;
            value_in = req_item.value;
            pos_in = req_item.position;
         end
         DP_CLEAR: begin
            count_in = '0;
            status_in = ST_OK;
            found_in = '0;
            removed_in = '0;
         end
         DP_REPORT: begin
            status_in = cmd.code;
            found_in = '0;
            removed_in = '0;
         end
         DP_UP_INIT: begin
            index_in = clamp_pos;
            ptr_in = last_idx;
         end
         DP_SCAN_INIT: ptr_in = '0;
         DP_SCAN_STEP: ptr_in = ptr_ff + IDX_W'(1);
         DP_FOUND: begin
            status_in = ST_OK;
            found_in = rd_addr_ff;
            removed_in = '0;
         end
         DP_TAKE: begin
            index_in = rd_addr_ff;
            ptr_in = rd_addr_ff + IDX_W'(1);
            removed_in = (op_ff == OP_DELETE_POS) ? rd_data : '0;
         end
         DP_STEP: ptr_in = is_insert ? (ptr_ff - IDX_W'(1)) : (ptr_ff + IDX_W'(1));
         DP_FINISH: begin
            count_in = is_insert ? (count_ff + CNT_W'(1)) : (count_ff - CNT_W'(1));
            status_in = ST_OK;
            found_in = index_ff;
            if (is_insert) begin
               removed_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
      op_ff <= op_in;
      value_ff <= value_in;
      pos_ff <= pos_in;
      index_ff <= index_in;
      ptr_ff <= ptr_in;
      rd_addr_ff <= rd_addr_in;
      status_ff <= status_in;
      found_ff <= found_in;
      removed_ff <= removed_in;
   end

   oal_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_item.status = status_ff;
   assign rsp_item.found_index = INDEX_FIELD_W'(found_ff);
   assign rsp_item.removed_value = removed_ff;
   assign rsp_item.entry_count = COUNT_FIELD_W'(count_ff);

endmodule

// File: sv/oal_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module oal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  oal_pkg::dp_status_type stat,
   output oal_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import oal_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_TAKE,
      S_SHIFT,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = done_ff;

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      cmd.op = DP_NONE;
      cmd.code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = DP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            done_in = 1'b1;
            case (stat.op)
               OP_CLEAR: cmd.op = DP_CLEAR;
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.op = DP_REPORT;
                     cmd.code = ST_FULL;
                  end else begin
                     cmd.op = DP_UP_INIT;
                     state_in = S_SHIFT;
                     done_in = 1'b0;
                  end
               end
               OP_FIND, OP_DELETE_VALUE: begin
                  if (stat.empty) begin
                     cmd.op = DP_REPORT;
                     cmd.code = ST_NOT_FOUND;
                  end else begin
                     cmd.op = DP_SCAN_INIT;
                     state_in = S_SCAN;
                     done_in = 1'b0;
                  end
               end
               OP_DELETE_POS: begin
                  if (stat.pos_ok) begin
                     cmd.op = DP_POS_READ;
                     state_in = S_TAKE;
                     done_in = 1'b0;
                  end else begin
                     cmd.op = DP_REPORT;
                     cmd.code = ST_RANGE;
                  end
               end
               default: cmd.op = DP_REPORT;
            endcase
         end
         S_SCAN: begin
            if (stat.match) begin
               if (stat.op == OP_FIND) begin
                  cmd.op = DP_FOUND;
                  state_in = S_IDLE;
                  done_in = 1'b1;
               end else begin
                  cmd.op = DP_TAKE;
                  state_in = S_SHIFT;
               end
            end else if (stat.scan_last) begin
               cmd.op = DP_REPORT;
               cmd.code = ST_NOT_FOUND;
               state_in = S_IDLE;
               done_in = 1'b1;
            end else begin
               cmd.op = DP_SCAN_STEP;
            end
         end
         S_TAKE: begin
            cmd.op = DP_TAKE;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.no_shift) begin
               cmd.op = DP_FINISH;
               state_in = S_IDLE;
               done_in = 1'b1;
            end else begin
               cmd.op = DP_STEP;
               if (stat.ptr_at_stop) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            cmd.op = DP_DRAIN;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op = DP_FINISH;
            state_in = S_IDLE;
            done_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: sv/ordered_array_list_core.sv
// Ordered list of signed 32-bit entries held in a RAM, one request at a time.
// A request is taken when start is high and busy is low; its single response appears on
// rsp_item for exactly one cycle with rsp_valid, and busy is already low in that cycle, so a
// new request may be started alongside it. The receiver cannot stall. The single read port
// of the entry RAM is walked one entry per cycle while scanning or shifting: clear, failed
// checks and unknown operations respond straight after decode; find scans up from index 0
// until the value matches or the last entry is read; insert at position p shifts the entries
// from the end down to p up by one place and then writes the value, or writes it directly
// when it appends; delete by position at index k shifts the entries after k down by one
// place, and delete by value first scans for k. No clearing pass is needed after reset.
module ordered_array_list_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  oal_pkg::req_type  req_item,
   output logic              busy,
   output logic              rsp_valid,
   output oal_pkg::rsp_type  rsp_item
);
   import oal_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;
   logic          ctrl_busy;

   assign busy = ctrl_busy;

   oal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (ctrl_busy),
      .rsp_valid (rsp_valid)
   );

   oal_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

// File: sv/oal_checker.sv
// Port-level checker for the ordered array list, bound to the top level.
module oal_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input oal_pkg::rsp_type  rsp_item
);
   import oal_pkg::*;

   // An accepted request always makes the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response shown while still busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   // Finishing a request always produces its response.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("request finished without a response");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_OK) |->
         (rsp_item.found_index == '0 && rsp_item.removed_value == '0))
      else $error("failed request reported an index or removed value");

endmodule

bind ordered_array_list_core oal_checker u_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the ordered array list core: queued requests, predicted responses.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import oal_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int TARGET_REQUESTS = 1525;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_NEG_ONE = -32'sd1;

   logic     clock;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   req_type  req_item = '0;
   logic     busy;
   logic     rsp_valid;
   rsp_type  rsp_item;

   req_type                   request_queue[$];
   rsp_type                   predicted_rsp[$];
   logic signed [DATA_W-1:0]  shadow_list[$];
   logic signed [DATA_W-1:0]  value_pool[8];

   int error_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 1;

   ordered_array_list_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int locate_value(input logic signed [DATA_W-1:0] v);
      for (int i = 0; i < shadow_list.size(); i++) begin
         if (shadow_list[i] == v) return i;
      end
      return -1;
   endfunction

   // Applies one request to the shadow list and returns the response it must produce.
   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type res;
      int      hit;
      int      p;
      res = '0;
      res.status = ST_OK;
      case (r.operation)
         OP_CLEAR: begin
            shadow_list.delete();
         end
         OP_INSERT: begin
            if (shadow_list.size() >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               p = int'(r.position);
               if (p > shadow_list.size()) p = shadow_list.size();
               shadow_list.insert(p, r.value);
               res.found_index = INDEX_FIELD_W'(p);
            end
         end
         OP_FIND: begin
            hit = locate_value(r.value);
            if (hit < 0) res.status = ST_NOT_FOUND;
            else res.found_index = INDEX_FIELD_W'(hit);
         end
         OP_DELETE_VALUE: begin
            hit = locate_value(r.value);
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               shadow_list.delete(hit);
               res.found_index = INDEX_FIELD_W'(hit);
            end
         end
         OP_DELETE_POS: begin
            p = int'(r.position);
            if (p < shadow_list.size()) begin
               res.removed_value = shadow_list[p];
               shadow_list.delete(p);
               res.found_index = INDEX_FIELD_W'(p);
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_FIELD_W'(shadow_list.size());
      return res;
   endfunction

   task automatic add_req(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos);
      req_type r;
      r.operation = op;
      r.value = val;
      r.position = pos;
      request_queue.push_back(r);
   endtask

   task automatic refresh_pool();
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 7))
            0: value_pool[i] = VAL_MIN;
            1: value_pool[i] = VAL_MAX;
            2: value_pool[i] = '0;
            3: value_pool[i] = VAL_NEG_ONE;
            default: value_pool[i] = $urandom;
         endcase
      end
   endtask

   // Values mostly come from a small pool so that finds and deletes by value often hit.
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return POS_W'(CAPACITY - 1);
            2: return POS_W'(CAPACITY);
            default: return '1;
         endcase
      end
      if (r < 30) return POS_W'($urandom_range(0, 255));
      return POS_W'($urandom_range(0, 15));
   endfunction

   // Fills the list to capacity, works on it while full, then drains part of it.
   task automatic fill_episode();
      int count;
      logic [POS_W-1:0] pos;
      refresh_pool();
      add_req(OP_CLEAR, $urandom, POS_W'($urandom_range(0, 255)));
      count = 0;
      while (count < CAPACITY) begin
         if ($urandom_range(0, 9) == 0) begin
            add_req(OP_FIND, pick_value(), POS_W'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 4)) inside
               0, 1: pos = POS_W'(count);
               2: pos = POS_W'($urandom_range(count, 255));
               default: pos = POS_W'($urandom_range(0, count));
            endcase
            add_req(OP_INSERT, pick_value(), pos);
            count++;
         end
      end
      for (int i = 0; i < 3; i++) add_req(OP_INSERT, pick_value(), pick_position());
      add_req(OP_FIND, pick_value(), POS_W'($urandom_range(0, 255)));
      add_req(OP_DELETE_POS, $urandom, POS_W'(CAPACITY - 1));
      add_req(OP_DELETE_POS, $urandom, POS_W'(CAPACITY - 1));
      add_req(OP_INSERT, pick_value(), '0);
      add_req(OP_INSERT, pick_value(), '0);
      add_req(OP_DELETE_POS, $urandom, POS_W'(CAPACITY));
      add_req(OP_DELETE_POS, $urandom, '1);
      add_req(OP_DELETE_VALUE, pick_value(), POS_W'($urandom_range(0, 255)));
      for (int i = 0; i < 40; i++) begin
         add_req(OP_DELETE_POS, $urandom, POS_W'($urandom_range(0, CAPACITY - 1)));
      end
   endtask

   task automatic mixed_episode();
      int r;
      logic [2:0] op;
      refresh_pool();
      if ($urandom_range(0, 9) < 4) add_req(OP_CLEAR, $urandom, POS_W'($urandom_range(0, 255)));
      repeat ($urandom_range(5, 30)) begin
         r = $urandom_range(0, 99);
         if (r < 3) op = OP_CLEAR;
         else if (r < 38) op = OP_INSERT;
         else if (r < 58) op = OP_FIND;
         else if (r < 73) op = OP_DELETE_VALUE;
         else if (r < 95) op = OP_DELETE_POS;
         else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         add_req(op, pick_value(), pick_position());
      end
   endtask

   task automatic directed_requests();
      add_req(OP_CLEAR, '0, '0);
      add_req(OP_FIND, 32'sd5, '0);
      add_req(OP_DELETE_VALUE, 32'sd5, '0);
      add_req(OP_DELETE_POS, '0, '0);
      add_req(OP_INSERT, VAL_MIN, '1);
      add_req(OP_INSERT, VAL_MAX, '0);
      add_req(OP_INSERT, VAL_NEG_ONE, 8'd1);
      add_req(OP_INSERT, '0, 8'd200);
      add_req(OP_INSERT, VAL_NEG_ONE, 8'd3);
      add_req(OP_FIND, VAL_NEG_ONE, '1);
      add_req(OP_FIND, '0, '0);
      add_req(OP_FIND, 32'sd12345, '0);
      add_req(OP_DELETE_VALUE, VAL_NEG_ONE, '1);
      add_req(OP_FIND, VAL_NEG_ONE, '0);
      add_req(OP_DELETE_POS, VAL_MAX, 8'd4);
      add_req(OP_DELETE_POS, '0, '1);
      add_req(OP_DELETE_POS, '0, 8'd3);
      add_req(OP_DELETE_POS, '0, '0);
      for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
         add_req(3'(op), $urandom, POS_W'($urandom_range(0, 255)));
      end
      add_req(OP_DELETE_VALUE, VAL_MIN, '0);
      add_req(OP_CLEAR, VAL_NEG_ONE, '1);
      add_req(OP_FIND, VAL_NEG_ONE, '0);
      add_req(OP_INSERT, 32'sh5A5A_5A5A, POS_W'(CAPACITY));
   endtask

   // Sender: holds a request until it is taken, then moves on in bursts with gaps between.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_item <= '0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         if (start && !busy) predicted_rsp.push_back(apply_list_op(req_item));
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (request_queue.size() != 0) begin
               req_item <= request_queue.pop_front();
               start <= 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (predicted_rsp.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = predicted_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.found_index !== want.found_index) begin
               $error("found_index: expected %0d, got %0d", want.found_index,
                      rsp_item.found_index);
               error_count++;
            end
            if (rsp_item.removed_value !== want.removed_value) begin
               $error("removed_value: expected %0d, got %0d", want.removed_value,
                      rsp_item.removed_value);
               error_count++;
            end
            if (rsp_item.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_item.entry_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int episode;
      directed_requests();
      episode = 0;
      while (request_queue.size() < TARGET_REQUESTS) begin
         if (episode == 0 || episode == 25) fill_episode();
         else mixed_episode();
         episode++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || start || predicted_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
